>>> rtl/core/plir_pkg.sv
// Shared types and constants of the point lens image remap block.
`timescale 1ns / 1ps

package plir_pkg;

  // Fixed field widths.
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 8;
  localparam int ERAD_W     = 24;
  localparam int SIZE_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Squared distance of an 8-bit offset pair, and |offset| times R^2.
  localparam int D2_W  = 17;
  localparam int NUM_W = COORD_W + ERAD_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERAD_SQ    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS       = 3'd4;

  // Register reset values.
  localparam logic [ERAD_W-1:0] ERAD_SQ_RESET = 24'd256;
  localparam logic [SIZE_W-1:0] SIZE_RESET    = 9'd256;

  // Item information that travels alongside the divider.
  typedef struct packed {
    logic               is_req;
    logic               kill;
    logic               neg_r;
    logic               neg_c;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pix;
  } side_t;

  // Write request into the frame store.
  typedef struct packed {
    logic               en;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pix;
  } wr_req_t;

  // The four neighbors of a source coordinate.
  typedef struct packed {
    logic [PIX_W-1:0] p00;
    logic [PIX_W-1:0] p01;
    logic [PIX_W-1:0] p10;
    logic [PIX_W-1:0] p11;
  } pix4_t;

endpackage

>>> rtl/core/plir_in_if.sv
// Input channel of the point lens image remap block.
`timescale 1ns / 1ps

interface plir_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] row;
  logic [7:0] col;
  logic [7:0] pixel_in;

  modport source (output valid, action, row, col, pixel_in, input ready);
  modport sink   (input valid, action, row, col, pixel_in, output ready);
endinterface

>>> rtl/core/plir_out_if.sv
// Output channel of the point lens image remap block.
`timescale 1ns / 1ps

interface plir_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_row;
  logic [7:0] out_col;
  logic [7:0] out_value;

  modport source (output valid, out_row, out_col, out_value, input ready);
  modport sink   (input valid, out_row, out_col, out_value, output ready);
endinterface

>>> rtl/core/point_lens_image_remap_unit.sv
// Top level of the point lens image remap block: lens warp pipeline and output register.
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Word
// req      in   valid/ready        action, row, col, pixel_in
// rsp      out  valid/ready        out_row, out_col, out_value
// cfg      in   cfg_we_i           cfg_idx_i, cfg_data_i (no back-pressure)
//
// One word is accepted per clock unless the pipeline holds. The long division computes one
// quotient bit per stage. Write words flow through the same stages and reach the frame
// store at the read stage, so reads and writes keep their order. Write words produce no
// output word. Reset clears valid bits and returns configuration registers to their
// reset values; the frame store is not cleared. The whole pipeline holds only when the
// output register is full and not taken while a request sits in the last stage;
// otherwise words keep moving.

module point_lens_image_remap_unit import plir_pkg::*; #(
  parameter int MAX_ROWS  = 256,
  parameter int MAX_COLS  = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  plir_in_if.sink               req,
  plir_out_if.source            rsp,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int SRN = RW + 1;
  localparam int SCN = CW + 1;
  localparam int QW  = NUM_W - COORD_W + FRAC_BITS;
  localparam int QSW = QW - 8;
  localparam int SRW = FRAC_BITS + 18;
  localparam int IW  = SRW - 1 - FRAC_BITS;

  typedef struct packed {
    logic               is_req;
    logic               ok;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } tail_t;

  // Configuration registers.
  logic [COORD_W-1:0] center_row_q, center_col_q;
  logic [ERAD_W-1:0]  erad_sq_q;
  logic [SIZE_W-1:0]  rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_row_q <= '0;
      center_col_q <= '0;
      erad_sq_q    <= ERAD_SQ_RESET;
      rows_q       <= SIZE_RESET;
      cols_q       <= SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_ROW: center_row_q <= cfg_data_i[COORD_W-1:0];
        REG_CENTER_COL: center_col_q <= cfg_data_i[COORD_W-1:0];
        REG_ERAD_SQ:    erad_sq_q    <= cfg_data_i[ERAD_W-1:0];
        REG_ROWS:       rows_q       <= cfg_data_i[SIZE_W-1:0];
        REG_COLS:       cols_q       <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Image size in use, clamped to [2, MAX].
  logic [SRN-1:0] rows_c, rows_m1;
  logic [SCN-1:0] cols_c, cols_m1;

  always_comb begin
    if (rows_q < SIZE_W'(2)) begin
      rows_c = SRN'(2);
    end else if (int'(rows_q) > MAX_ROWS) begin
      rows_c = SRN'(MAX_ROWS);
    end else begin
      rows_c = SRN'(rows_q);
    end
    if (cols_q < SIZE_W'(2)) begin
      cols_c = SCN'(2);
    end else if (int'(cols_q) > MAX_COLS) begin
      cols_c = SCN'(MAX_COLS);
    end else begin
      cols_c = SCN'(cols_q);
    end
  end

  assign rows_m1 = rows_c - SRN'(1);
  assign cols_m1 = cols_c - SCN'(1);

  // Pipeline advance: only a finished request blocked at the output stops the stages.
  logic out_v_q;
  logic out_free;
  logic prod8;
  logic adv;

  assign out_free  = !out_v_q || rsp.ready;
  assign adv       = out_free || !prod8;
  assign req.ready = adv;

  // Stage 1: offsets from the lens center.
  logic [8:0]         dr, dc, ndr, ndc;
  logic               v1_q;
  side_t              side1_q;
  logic [COORD_W-1:0] mag_r1_q, mag_c1_q;

  assign dr  = {1'b0, req.row} - {1'b0, center_row_q};
  assign dc  = {1'b0, req.col} - {1'b0, center_col_q};
  assign ndr = 9'd0 - dr;
  assign ndc = 9'd0 - dc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side1_q.is_req <= req.action;
      side1_q.kill   <= (int'(req.row) >= int'(rows_c)) || (int'(req.col) >= int'(cols_c));
      side1_q.neg_r  <= dr[8];
      side1_q.neg_c  <= dc[8];
      side1_q.row    <= req.row;
      side1_q.col    <= req.col;
      side1_q.pix    <= req.pixel_in;
      mag_r1_q       <= dr[8] ? ndr[7:0] : dr[7:0];
      mag_c1_q       <= dc[8] ? ndc[7:0] : dc[7:0];
    end
  end

  // Stage 2: squares and |offset| * R^2.
  logic               v2_q;
  side_t              side2_q;
  logic [15:0]        sq_r2_q, sq_c2_q;
  logic [NUM_W-1:0]   n_r2_q, n_c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side2_q <= side1_q;
      sq_r2_q <= mag_r1_q * mag_r1_q;
      sq_c2_q <= mag_c1_q * mag_c1_q;
      n_r2_q  <= mag_r1_q * erad_sq_q;
      n_c2_q  <= mag_c1_q * erad_sq_q;
    end
  end

  // Stage 3: squared distance; the lens center itself returns zero.
  logic [D2_W-1:0]  d2_2;
  side_t            side3_d;
  logic             v3_q;
  side_t            side3_q;
  logic [D2_W-1:0]  d2_3_q;
  logic [NUM_W-1:0] num3_q [2];

  assign d2_2 = {1'b0, sq_r2_q} + {1'b0, sq_c2_q};

  always_comb begin
    side3_d      = side2_q;
    side3_d.kill = side2_q.kill || (d2_2 == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side3_q      <= side3_d;
      d2_3_q       <= d2_2;
      num3_q[0]    <= n_r2_q;
      num3_q[1]    <= n_c2_q;
    end
  end

  // Division: floor(|offset| * R^2 * 2^FRAC_BITS / d2), then the /256 of Q16.8 is a shift.
  logic          vd;
  side_t         sided;
  logic [QW-1:0] quo [2];

  plir_div_pipe #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .side_i  (side3_q),
    .d2_i    (d2_3_q),
    .num_i   (num3_q),
    .valid_o (vd),
    .side_o  (sided),
    .quo_o   (quo)
  );

  // Stage 4: source coordinate = position minus the signed shrink term.
  logic [SRW-1:0] base_r, base_c, qx_r, qx_c;
  logic           v4_q;
  side_t          side4_q;
  logic [SRW-1:0] sr4_q, sc4_q;

  assign base_r = {{(SRW-COORD_W-FRAC_BITS){1'b0}}, sided.row, {FRAC_BITS{1'b0}}};
  assign base_c = {{(SRW-COORD_W-FRAC_BITS){1'b0}}, sided.col, {FRAC_BITS{1'b0}}};
  assign qx_r   = {{(SRW-QSW){1'b0}}, quo[0][QW-1:8]};
  assign qx_c   = {{(SRW-QSW){1'b0}}, quo[1][QW-1:8]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side4_q <= sided;
      sr4_q   <= sided.neg_r ? base_r + qx_r : base_r - qx_r;
      sc4_q   <= sided.neg_c ? base_c + qx_c : base_c - qx_c;
    end
  end

  // Stage 5: interior check, split into integer and fraction, then the store access.
  logic [IW-1:0]        int_r, int_c;
  logic                 pos_r, pos_c, in_r, in_c;
  logic                 v5_q;
  side_t                side5_q;
  logic                 ok5_q;
  logic [RW-1:0]        ir5_q;
  logic [CW-1:0]        ic5_q;
  logic [FRAC_BITS-1:0] fr5_q, fc5_q;

  assign int_r = sr4_q[SRW-2:FRAC_BITS];
  assign int_c = sc4_q[SRW-2:FRAC_BITS];
  assign pos_r = !sr4_q[SRW-1] && (sr4_q != '0);
  assign pos_c = !sc4_q[SRW-1] && (sc4_q != '0);
  assign in_r  = int_r < IW'(rows_m1);
  assign in_c  = int_c < IW'(cols_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side5_q <= side4_q;
      ok5_q   <= side4_q.is_req && !side4_q.kill && pos_r && pos_c && in_r && in_c;
      ir5_q   <= int_r[RW-1:0];
      ic5_q   <= int_c[CW-1:0];
      fr5_q   <= sr4_q[FRAC_BITS-1:0];
      fc5_q   <= sc4_q[FRAC_BITS-1:0];
    end
  end

  wr_req_t wr;
  pix4_t   pix6;

  assign wr.en  = adv && v5_q && !side5_q.is_req;
  assign wr.row = side5_q.row;
  assign wr.col = side5_q.col;
  assign wr.pix = side5_q.pix;

  plir_frame_store #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_store (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .rd_en_i  (adv && v5_q && side5_q.is_req),
    .rd_row_i (ir5_q),
    .rd_col_i (ic5_q),
    .pix_o    (pix6)
  );

  // Stages 6 to 8: pixel data, then the two blend passes.
  logic                 v6_q, v7_q, v8_q;
  tail_t                t6_q, t7_q, t8_q;
  logic [FRAC_BITS-1:0] fr6_q, fc6_q;
  logic [PIX_W-1:0]     blend_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (adv) begin
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t6_q.is_req <= side5_q.is_req;
      t6_q.ok     <= ok5_q;
      t6_q.row    <= side5_q.row;
      t6_q.col    <= side5_q.col;
      fr6_q       <= fr5_q;
      fc6_q       <= fc5_q;
      t7_q        <= t6_q;
      t8_q        <= t7_q;
    end
  end

  plir_blend #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blend (
    .clk_i   (clk_i),
    .en_i    (adv),
    .pix_i   (pix6),
    .fr_i    (fr6_q),
    .fc_i    (fc6_q),
    .value_o (blend_val)
  );

  assign prod8 = v8_q && t8_q.is_req;

  // Output register: loads whenever it is empty or being taken.
  logic [COORD_W-1:0] out_row_q, out_col_q;
  logic [PIX_W-1:0]   out_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= prod8;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_row_q <= t8_q.row;
      out_col_q <= t8_q.col;
      out_val_q <= t8_q.ok ? blend_val : '0;
    end
  end

  assign rsp.valid     = out_v_q;
  assign rsp.out_row   = out_row_q;
  assign rsp.out_col   = out_col_q;
  assign rsp.out_value = out_val_q;

  // A request at the lens center must be marked for a zero result.
  a_center_kill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && side3_q.is_req && (d2_3_q == '0)) |-> side3_q.kill)
    else $error("center request not killed");

  // A killed or out-of-range request leaving the pipeline shows up as a zero output word.
  a_kill_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v8_q && t8_q.is_req && !t8_q.ok && out_free) |=> (rsp.valid && (rsp.out_value == 8'd0)))
    else $error("killed request gave nonzero value");

  // A request blocked at the output keeps its place in the last stage.
  a_hold_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v8_q && t8_q.is_req && out_v_q && !rsp.ready) |=> (v8_q && t8_q.is_req && $stable(t8_q)))
    else $error("last stage lost a blocked request");

endmodule

>>> rtl/core/plir_div_pipe.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
`timescale 1ns / 1ps

module plir_div_pipe import plir_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int QW = NUM_W - COORD_W + FRAC_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  side_t            side_i,
  input  logic [D2_W-1:0]  d2_i,
  input  logic [NUM_W-1:0] num_i [2],
  output logic             valid_o,
  output side_t            side_o,
  output logic [QW-1:0]    quo_o [2]
);

  logic                v_q    [QW];
  side_t               side_q [QW];
  logic [D2_W-1:0]     d2_q   [QW];
  logic [D2_W-1:0]     rem_q  [QW][2];
  logic [QW-1:0]       quo_q  [QW][2];
  logic [ERAD_W-1:0]   num_q  [QW][2];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic            vin;
    side_t           sin;
    logic [D2_W-1:0] din;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign sin = side_i;
      assign din = d2_i;
    end else begin : g_next
      assign vin = v_q[k-1];
      assign sin = side_q[k-1];
      assign din = d2_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= sin;
        d2_q[k]   <= din;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [D2_W-1:0]   rin;
      logic [QW-1:0]     qin;
      logic [ERAD_W-1:0] nin;
      logic              dbit;
      logic [D2_W:0]     sh;
      logic [D2_W:0]     diff;
      logic              ge;

      if (k == 0) begin : g_first
        // The quotient fits QW bits, so the top dividend bits start below the divisor.
        assign rin = D2_W'(num_i[l][NUM_W-1:ERAD_W]);
        assign qin = '0;
        assign nin = num_i[l][ERAD_W-1:0];
      end else begin : g_next
        assign rin = rem_q[k-1][l];
        assign qin = quo_q[k-1][l];
        assign nin = num_q[k-1][l];
      end

      if (QW - 1 - k >= FRAC_BITS) begin : g_nbit
        assign dbit = nin[QW-1-k-FRAC_BITS];
      end else begin : g_zbit
        assign dbit = 1'b0;
      end

      assign sh   = {rin, dbit};
      assign ge   = (sh >= {1'b0, din});
      assign diff = sh - {1'b0, din};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= ge ? diff[D2_W-1:0] : sh[D2_W-1:0];
          quo_q[k][l] <= {qin[QW-2:0], ge};
          num_q[k][l] <= nin;
        end
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign side_o  = side_q[QW-1];
  assign quo_o[0] = quo_q[QW-1][0];
  assign quo_o[1] = quo_q[QW-1][1];

endmodule

>>> rtl/core/plir_frame_store.sv
// Source frame store split into four row/column parity banks.
`timescale 1ns / 1ps

module plir_frame_store import plir_pkg::*; #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = $clog2(MAX_COLS)
) (
  input  logic          clk_i,
  input  wr_req_t       wr_i,
  input  logic          rd_en_i,
  input  logic [RW-1:0] rd_row_i,
  input  logic [CW-1:0] rd_col_i,
  output pix4_t         pix_o
);

  localparam int HR    = (MAX_ROWS + 1) / 2;
  localparam int HC    = (MAX_COLS + 1) / 2;
  localparam int DEPTH = HR * HC;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          wr_ok;
  logic [1:0]    wr_bank;
  logic [AW-1:0] wr_addr;
  logic [PIX_W-1:0] data_q [4];
  logic          sel_r_q;
  logic          sel_c_q;
  logic [PIX_W-1:0] r0c, r0n, r1c, r1n;

  assign wr_ok   = wr_i.en && (int'(wr_i.row) < MAX_ROWS) && (int'(wr_i.col) < MAX_COLS);
  assign wr_bank = {wr_i.row[0], wr_i.col[0]};
  assign wr_addr = AW'(int'(wr_i.row >> 1) * HC + int'(wr_i.col >> 1));

  // Each bank holds one parity pair, so the four neighbors land in four banks.
  for (genvar g = 0; g < 4; g++) begin : g_bank
    localparam logic BANK_R = 1'((g >> 1) & 1);
    localparam logic BANK_C = 1'(g & 1);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [RW-1:0]    r_sel;
    logic [CW-1:0]    c_sel;
    logic [AW-1:0]    rd_addr;

    assign r_sel   = rd_row_i + RW'(rd_row_i[0] != BANK_R);
    assign c_sel   = rd_col_i + CW'(rd_col_i[0] != BANK_C);
    assign rd_addr = AW'(int'(r_sel >> 1) * HC + int'(c_sel >> 1));

    always_ff @(posedge clk_i) begin
      if (wr_ok && (wr_bank == 2'(g))) begin
        mem[wr_addr] <= wr_i.pix;
      end
      if (rd_en_i) begin
        data_q[g] <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      sel_r_q <= rd_row_i[0];
      sel_c_q <= rd_col_i[0];
    end
  end

  // Undo the parity rotation: r0/r1 are the even/odd row banks.
  assign r0c = sel_c_q ? data_q[1] : data_q[0];
  assign r0n = sel_c_q ? data_q[0] : data_q[1];
  assign r1c = sel_c_q ? data_q[3] : data_q[2];
  assign r1n = sel_c_q ? data_q[2] : data_q[3];

  assign pix_o.p00 = sel_r_q ? r1c : r0c;
  assign pix_o.p01 = sel_r_q ? r1n : r0n;
  assign pix_o.p10 = sel_r_q ? r0c : r1c;
  assign pix_o.p11 = sel_r_q ? r0n : r1n;

endmodule

>>> rtl/core/plir_blend.sv
// Two-stage bilinear blend of four neighbor pixels.
`timescale 1ns / 1ps

module plir_blend import plir_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  pix4_t                pix_i,
  input  logic [FRAC_BITS-1:0] fr_i,
  input  logic [FRAC_BITS-1:0] fc_i,
  output logic [PIX_W-1:0]     value_o
);

  localparam int ONE_W = FRAC_BITS + 1;
  localparam int PW    = PIX_W + ONE_W;
  localparam int HW    = PIX_W + FRAC_BITS;
  localparam int MW    = HW + ONE_W;

  logic [ONE_W-1:0]     wc0, wr0;
  logic [PW-1:0]        a0, a1, b0, b1;
  logic [PW:0]          s0, s1;
  logic [HW-1:0]        h0_q, h1_q;
  logic [FRAC_BITS-1:0] fr_q;
  logic [MW-1:0]        m0_q, m1_q;
  logic [MW:0]          acc;

  // Horizontal pass: blend each row pair along the column fraction.
  assign wc0 = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fc_i};
  assign a0  = pix_i.p00 * wc0;
  assign a1  = pix_i.p01 * {1'b0, fc_i};
  assign b0  = pix_i.p10 * wc0;
  assign b1  = pix_i.p11 * {1'b0, fc_i};
  assign s0  = {1'b0, a0} + {1'b0, a1};
  assign s1  = {1'b0, b0} + {1'b0, b1};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h0_q <= s0[HW-1:0];
      h1_q <= s1[HW-1:0];
      fr_q <= fr_i;
    end
  end

  // Vertical pass along the row fraction.
  assign wr0 = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fr_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q <= h0_q * wr0;
      m1_q <= h1_q * {1'b0, fr_q};
    end
  end

  assign acc     = {1'b0, m0_q} + {1'b0, m1_q};
  assign value_o = acc[2*FRAC_BITS +: PIX_W];

endmodule
